### rtl/text_mode_glyph_line_renderer_defines.svh
// ----------------------------------------------------------------------------
// Text-mode glyph line renderer: assertion macros
// Shared property wrappers, all clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_GLYPH_LINE_RENDERER_DEFINES_SVH
`define TEXT_MODE_GLYPH_LINE_RENDERER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define TMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tmg_pkg.sv
// ----------------------------------------------------------------------------
// Text-mode glyph line renderer package
// Shared constants, function codes, the line record and colour widening.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmg_pkg;

    localparam int FONT_LINES  = 16;
    localparam int CELL_WIDTH  = 9;
    localparam int GLYPH_COUNT = 256;
    localparam int PAL_DEPTH   = 16;

    localparam int FONT_ADDR_W = $clog2(GLYPH_COUNT * FONT_LINES);
    localparam int PAL_ADDR_W  = $clog2(PAL_DEPTH);
    localparam int COL_W       = 4;
    localparam int PAL_W       = 18;
    localparam int RGB_W       = 24;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(CELL_WIDTH - 1);

    // Codes from 0xC0 to 0xDF are line-drawing glyphs.
    localparam logic [7:0] BOX_BASE = 8'hC0;
    localparam logic [7:0] BOX_END  = 8'hE0;

    typedef enum logic [1:0] {
        FUNC_RENDER = 2'd0,
        FUNC_PAL    = 2'd1,
        FUNC_FONT   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [RGB_W-1:0]      fg;
        logic [RGB_W-1:0]      bg;
        logic [CELL_WIDTH-1:0] pattern;
    } line_t;

    function automatic logic [RGB_W-1:0] widen_color(input logic [PAL_W-1:0] c);
        widen_color = {c[17:12], 2'b00, c[11:6], 2'b00, c[5:0], 2'b00};
    endfunction

endpackage

`default_nettype wire

### rtl/tmg_font_mem.sv
// ----------------------------------------------------------------------------
// Font store
// Simple dual-port synchronous RAM of glyph lines: one write port and a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmg_font_mem
    import tmg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [FONT_ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]             wr_data,
    input  wire logic                   rd_en,
    input  wire logic [FONT_ADDR_W-1:0] rd_addr,
    output logic      [7:0]             rd_data
);

    logic [7:0] mem [GLYPH_COUNT*FONT_LINES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/tmg_pal_mem.sv
// ----------------------------------------------------------------------------
// Palette store
// Sixteen 18-bit colours, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmg_pal_mem
    import tmg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [PAL_ADDR_W-1:0] wr_addr,
    input  wire logic [PAL_W-1:0]      wr_data,
    input  wire logic                  rd_en,
    input  wire logic [PAL_ADDR_W-1:0] fg_addr,
    input  wire logic [PAL_ADDR_W-1:0] bg_addr,
    output logic      [PAL_W-1:0]      fg_data,
    output logic      [PAL_W-1:0]      bg_data
);

    logic [PAL_W-1:0] mem [PAL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fg_data <= mem[fg_addr];
            bg_data <= mem[bg_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/tmg_pixel_ser.sv
// ----------------------------------------------------------------------------
// Pixel serialiser
// Holds one rendered line and presents its nine pixels, one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmg_pixel_ser
    import tmg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             line_valid,
    input  wire line_t            line_in,
    output logic                  line_take,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [RGB_W-1:0]      pixel_rgb,
    output logic [COL_W-1:0]      pixel_column,
    output logic                  last_pixel
);

    logic             busy_reg, busy_next;
    logic [COL_W-1:0] col_reg, col_next;
    line_t            line_reg, line_next;
    logic             fire;
    logic             at_last;
    logic [COL_W-1:0] bit_idx;

    assign fire      = busy_reg && !out_stall;
    assign at_last   = (col_reg == LAST_COL);
    assign line_take = line_valid && (!busy_reg || (fire && at_last));

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        line_next = line_reg;
        if (line_take)
        begin
            busy_next = 1'b1;
            col_next  = '0;
            line_next = line_in;
        end
        else if (fire && at_last)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    // The pattern is stored with column 0 in its top bit.
    assign bit_idx      = LAST_COL - col_reg;
    assign out_valid    = busy_reg;
    assign pixel_rgb    = line_reg.pattern[bit_idx] ? line_reg.fg : line_reg.bg;
    assign pixel_column = col_reg;
    assign last_pixel   = at_last;

endmodule

`default_nettype wire

### rtl/text_mode_glyph_line_renderer.sv
// A render accepted at the input is registered in the lookup stage (the store read registers)
// and then loaded into the serialiser's line register before its first pixel is shown.
// Throughput: one pixel per clock while out_stall is low; the next line is taken as the last
// pixel is accepted. Store writes are held off only while a render waits for the serialiser.
// Reset clears the handshake and sequencing state; palette and font stores are
// undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// Text-mode glyph line renderer
// Palette and font stores with a lookup stage feeding a nine-pixel serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_mode_glyph_line_renderer_defines.svh"

module text_mode_glyph_line_renderer
    import tmg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [7:0]        char_code,
    input  wire logic [7:0]        attribute,
    input  wire logic [3:0]        glyph_line,
    input  wire logic [3:0]        pal_index,
    input  wire logic [23:0]       pal_color,
    input  wire logic [7:0]        font_bits,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [RGB_W-1:0]       pixel_rgb,
    output logic [COL_W-1:0]       pixel_column,
    output logic                   last_pixel
);

    logic                   in_fire;
    func_t                  func_code;
    logic                   line_ok;
    logic [FONT_ADDR_W-1:0] font_addr;
    logic                   rd_en;
    logic                   font_wr_en;
    logic                   pal_wr_en;
    logic [PAL_W-1:0]       pal_packed;
    logic [7:0]             font_rd;
    logic [PAL_W-1:0]       fg_rd;
    logic [PAL_W-1:0]       bg_rd;
    logic [7:0]             row;
    line_t                  s1_line;
    logic                   s1_take;

    logic s1_valid_reg, s1_valid_next;
    logic s1_box_reg, s1_box_next;
    logic s1_line_ok_reg, s1_line_ok_next;

    assign func_code = func_t'(func);
    assign in_fire   = in_valid && !in_stall;

    // A render holds the lookup stage until the serialiser takes it; the
    // memory read registers stay put because no further read is issued.
    assign in_stall = s1_valid_reg && !s1_take;

    assign line_ok   = (32'(glyph_line) < FONT_LINES);
    assign font_addr = FONT_ADDR_W'(32'(char_code) * FONT_LINES + 32'(glyph_line));

    assign rd_en      = in_fire && (func_code == FUNC_RENDER);
    assign font_wr_en = in_fire && (func_code == FUNC_FONT) && line_ok;
    assign pal_wr_en  = in_fire && (func_code == FUNC_PAL);
    assign pal_packed = {pal_color[21:16], pal_color[13:8], pal_color[5:0]};

    tmg_font_mem u_font_mem (
        .clk     (clk),
        .wr_en   (font_wr_en),
        .wr_addr (font_addr),
        .wr_data (font_bits),
        .rd_en   (rd_en),
        .rd_addr (font_addr),
        .rd_data (font_rd)
    );

    tmg_pal_mem u_pal_mem (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (pal_index),
        .wr_data (pal_packed),
        .rd_en   (rd_en),
        .fg_addr (attribute[3:0]),
        .bg_addr ({1'b0, attribute[6:4]}),
        .fg_data (fg_rd),
        .bg_data (bg_rd)
    );

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_box_next     = s1_box_reg;
        s1_line_ok_next = s1_line_ok_reg;
        if (rd_en)
        begin
            s1_valid_next   = 1'b1;
            s1_box_next     = (char_code >= BOX_BASE) && (char_code < BOX_END);
            s1_line_ok_next = line_ok;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_box_reg     <= s1_box_next;
        s1_line_ok_reg <= s1_line_ok_next;
    end

    // A line beyond the cell reads as blank.
    assign row = s1_line_ok_reg ? font_rd : 8'h00;

    always_comb
    begin
        s1_line.fg      = widen_color(fg_rd);
        s1_line.bg      = widen_color(bg_rd);
        s1_line.pattern = {row, s1_box_reg & row[0]};
    end

    tmg_pixel_ser u_pixel_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (s1_valid_reg),
        .line_in      (s1_line),
        .line_take    (s1_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_rgb    (pixel_rgb),
        .pixel_column (pixel_column),
        .last_pixel   (last_pixel)
    );

    `TMG_ASSERT_NOW(a_lookup_free_no_stall, !s1_valid_reg, !in_stall,
        "input stalled while the lookup stage is empty")
    `TMG_ASSERT_NEXT(a_lookup_held, s1_valid_reg && !s1_take, s1_valid_reg,
        "pending render lost from the lookup stage")
    `TMG_ASSERT_NEXT(a_column_advance, out_valid && !out_stall && !last_pixel,
        out_valid && (pixel_column == COL_W'($past(pixel_column) + COL_W'(1))),
        "pixel sequence broken within a line")
    `TMG_ASSERT_NOW(a_last_column, out_valid && last_pixel,
        pixel_column == LAST_COL, "last pixel flagged on the wrong column")

endmodule

`default_nettype wire
